// ===== src/yuv420_pkg.sv =====
// ----------------------------------------------------------------------------
// yuv420_pkg
// Shared types and constants for the packed 4:2:2 to planar 4:2:0 converter.
// ----------------------------------------------------------------------------
package yuv420_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_PAIRS_PER_ROW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_PER_FRAME = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PACKING_ORDER  = 2'd2;

    // register widths and reset values
    localparam int PAIRS_REG_W = 12;
    localparam int ROWS_REG_W  = 13;

    localparam logic [PAIRS_REG_W-1:0] PAIRS_RESET = 12'd360;
    localparam logic [ROWS_REG_W-1:0]  ROWS_RESET  = 13'd480;

    // byte order of a macropixel
    localparam logic ORDER_YUYV = 1'b0;
    localparam logic ORDER_UYVY = 1'b1;

    // fields of one macropixel after the byte order is resolved
    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] u;
        logic [7:0] v;
        logic       odd_row;
        logic       row_end;
        logic       frame_end;
    } pix_stage_t;

endpackage

// ===== src/packed_yuv422_to_planar_i420.sv =====
// ----------------------------------------------------------------------------
// packed_yuv422_to_planar_i420
// Converts packed YUY2/UYVY macropixels to luma pairs plus 4:2:0 chroma.
// ----------------------------------------------------------------------------
// Usage:
//   pix channel: one 32-bit macropixel per transfer, raster order, byte 0 in
//   bits 7:0. res channel: one result per macropixel with both luma bytes,
//   row/frame end flags and, on odd rows, the two-row chroma averages.
//   cfg channel: write-only registers (pairs_per_row, rows_per_frame,
//   packing_order), always ready; write only while the block is idle.
// Timing:
//   the transfer edge loads the macropixel and its line store entry into the
//   read stage, and the result register takes the averages from the read
//   stage once it is free. Throughput is one macropixel per cycle while
//   res_ready stays high: the line store takes one write and one read per
//   cycle.
// Reset:
//   counters return to the top-left of a frame and registers to 360 pairs,
//   480 rows, Y-first order. The line store is not cleared; even rows fill it
//   before odd rows read it.
// Stall:
//   when res_ready is low the result register holds, the read stage fills,
//   and pix_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module packed_yuv422_to_planar_i420 #(
    parameter int MAX_PAIRS = 2048,
    parameter int MAX_ROWS  = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [yuv420_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [yuv420_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  logic [31:0]                         macropixel,

    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [7:0]                          luma_first,
    output logic [7:0]                          luma_second,
    output logic                                chroma_valid,
    output logic [7:0]                          u_average,
    output logic [7:0]                          v_average,
    output logic                                row_end,
    output logic                                frame_end
);

    import yuv420_pkg::*;

    localparam int COL_W = $clog2(MAX_PAIRS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    // configuration registers
    logic [PAIRS_REG_W-1:0] pairs_reg;
    logic [ROWS_REG_W-1:0]  rows_reg;
    logic                   order_reg;

    // position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // read stage and result stage
    logic        s1_valid_reg;
    pix_stage_t  s1_reg;
    logic [15:0] rd_data_reg;

    logic        res_valid_reg;
    logic [7:0]  luma_first_reg;
    logic [7:0]  luma_second_reg;
    logic        chroma_valid_reg;
    logic [7:0]  u_average_reg;
    logic [7:0]  v_average_reg;
    logic        row_end_reg;
    logic        frame_end_reg;

    logic [15:0] line_mem [MAX_PAIRS];

    logic        pix_fire;
    logic        res_load;
    logic [31:0] eff_pairs;
    logic [31:0] eff_rows;
    logic        rend;
    logic        fend;
    pix_stage_t  s0;
    logic [8:0]  u_sum;
    logic [8:0]  v_sum;

    // configuration write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_reg <= PAIRS_RESET;
            rows_reg  <= ROWS_RESET;
            order_reg <= ORDER_YUYV;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PAIRS_PER_ROW:  pairs_reg <= cfg_data[PAIRS_REG_W-1:0];
                REG_ROWS_PER_FRAME: rows_reg  <= cfg_data[ROWS_REG_W-1:0];
                REG_PACKING_ORDER:  order_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // clamped frame limits
    always_comb
    begin
        eff_pairs = 32'(pairs_reg);
        if (pairs_reg == '0)
            eff_pairs = 32'd1;
        else if (32'(pairs_reg) > 32'(MAX_PAIRS))
            eff_pairs = 32'(MAX_PAIRS);

        eff_rows = 32'(rows_reg);
        if (rows_reg == '0)
            eff_rows = 32'd1;
        else if (32'(rows_reg) > 32'(MAX_ROWS))
            eff_rows = 32'(MAX_ROWS);
    end

    // handshake: result register drains, read stage refills behind it
    assign res_load  = s1_valid_reg && (!res_valid_reg || res_ready);
    assign pix_ready = !s1_valid_reg || res_load;
    assign pix_fire  = pix_valid && pix_ready;

    // byte order and row/frame end of the incoming macropixel
    assign rend = (32'(col_reg) + 32'd1) >= eff_pairs;
    assign fend = rend && ((32'(row_reg) + 32'd1) >= eff_rows);

    always_comb
    begin
        case (order_reg)
            ORDER_UYVY:
            begin
                s0.u  = macropixel[7:0];
                s0.y0 = macropixel[15:8];
                s0.v  = macropixel[23:16];
                s0.y1 = macropixel[31:24];
            end
            default:
            begin
                s0.y0 = macropixel[7:0];
                s0.u  = macropixel[15:8];
                s0.y1 = macropixel[23:16];
                s0.v  = macropixel[31:24];
            end
        endcase
        s0.odd_row   = row_reg[0];
        s0.row_end   = rend;
        s0.frame_end = fend;
    end

    // counter update
    always_comb
    begin
        col_next = col_reg + 1'b1;
        row_next = row_reg;
        if (rend)
        begin
            col_next = '0;
            row_next = fend ? '0 : row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // chroma line store: even rows write, every transfer reads, odd rows use the read
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            if (!row_reg[0])
                line_mem[col_reg] <= {s0.v, s0.u};
            rd_data_reg <= line_mem[col_reg];
        end
    end

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pix_ready)
            s1_valid_reg <= pix_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
            s1_reg <= s0;
    end

    // truncating two-row average
    assign u_sum = {1'b0, rd_data_reg[7:0]}  + {1'b0, s1_reg.u};
    assign v_sum = {1'b0, rd_data_reg[15:8]} + {1'b0, s1_reg.v};

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            luma_first_reg   <= s1_reg.y0;
            luma_second_reg  <= s1_reg.y1;
            chroma_valid_reg <= s1_reg.odd_row;
            u_average_reg    <= s1_reg.odd_row ? u_sum[8:1] : 8'd0;
            v_average_reg    <= s1_reg.odd_row ? v_sum[8:1] : 8'd0;
            row_end_reg      <= s1_reg.row_end;
            frame_end_reg    <= s1_reg.frame_end;
        end
    end

    assign res_valid    = res_valid_reg;
    assign luma_first   = luma_first_reg;
    assign luma_second  = luma_second_reg;
    assign chroma_valid = chroma_valid_reg;
    assign u_average    = u_average_reg;
    assign v_average    = v_average_reg;
    assign row_end      = row_end_reg;
    assign frame_end    = frame_end_reg;

`ifndef NO_ASSERTIONS
    // a frame always ends at the end of a row
    a_frame_end_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!frame_end || row_end))
        else $error("frame_end without row_end");

    // averages are zero whenever no chroma is given
    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !chroma_valid) |-> (u_average == 8'd0 && v_average == 8'd0))
        else $error("chroma averages nonzero on an even row");

    // a row end wraps the column counter
    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_fire && rend) |=> (col_reg == '0))
        else $error("column counter did not wrap at row end");

    // a frame end returns to row zero
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_fire && fend) |=> (row_reg == '0))
        else $error("row counter did not wrap at frame end");

    // read stage holds its item while the result register is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !res_load) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("read stage lost its item under stall");
`endif

endmodule

// ===== verif/packed_yuv422_to_planar_i420_tb.sv =====
// ----------------------------------------------------------------------------
// packed_yuv422_to_planar_i420_tb
// Self-checking bench for the packed 4:2:2 to planar 4:2:0 converter. A
// cycle-free predictor tracks the row/column counters, the chroma line and
// the registers, and every result transfer is compared field by field.
// Directed frames cover both byte orders, byte extremes, size clamping and
// resizing mid-frame. Random frames follow, with random idle cycles on
// both channels.
// ----------------------------------------------------------------------------
module packed_yuv422_to_planar_i420_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import yuv420_pkg::*;

    localparam int LINE_PAIRS = 2048;
    localparam int FRAME_ROWS = 4096;
    localparam int SLOT_W = $clog2(LINE_PAIRS);
    localparam int RANDOM_ITEMS = 1010;
    localparam int IDLE_MAX = 13;
    localparam int SETTLE_CYCLES = 4;

    // no register behind this index, writes are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic       chroma_valid;
        logic [7:0] u_average;
        logic [7:0] v_average;
        logic       row_end;
        logic       frame_end;
    } conv_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   pix_valid;
    logic                   pix_ready;
    logic [31:0]            macropixel;
    logic                   res_valid;
    logic                   res_ready;
    logic [7:0]             luma_first;
    logic [7:0]             luma_second;
    logic                   chroma_valid;
    logic [7:0]             u_average;
    logic [7:0]             v_average;
    logic                   row_end;
    logic                   frame_end;

    // predictor registers and state
    logic [PAIRS_REG_W-1:0] pairs_reg = PAIRS_RESET;
    logic [ROWS_REG_W-1:0]  rows_reg  = ROWS_RESET;
    logic                   order_reg = ORDER_YUYV;
    int unsigned            column_pos = 0;
    int unsigned            row_pos = 0;
    logic [7:0]             line_u [LINE_PAIRS];
    logic [7:0]             line_v [LINE_PAIRS];
    bit                     line_filled [LINE_PAIRS];

    conv_result_t           pending_results [$];
    conv_result_t           oldest;

    int unsigned            gap_max = IDLE_MAX;
    int unsigned            ready_hold = 0;
    int unsigned            error_count = 0;
    int unsigned            items_sent = 0;
    int unsigned            regs_written = 0;
    int unsigned            chroma_checked = 0;
    int unsigned            frames_seen = 0;

    packed_yuv422_to_planar_i420 #(
        .MAX_PAIRS (LINE_PAIRS),
        .MAX_ROWS  (FRAME_ROWS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pix_valid    (pix_valid),
        .pix_ready    (pix_ready),
        .macropixel   (macropixel),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .luma_first   (luma_first),
        .luma_second  (luma_second),
        .chroma_valid (chroma_valid),
        .u_average    (u_average),
        .v_average    (v_average),
        .row_end      (row_end),
        .frame_end    (frame_end)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // effective frame size after clamping
    function automatic int unsigned active_pairs();
        int unsigned pairs;
        pairs = 32'(pairs_reg);
        if (pairs == 0)
            return 1;
        return (pairs > LINE_PAIRS) ? LINE_PAIRS : pairs;
    endfunction

    function automatic int unsigned active_rows();
        int unsigned rows;
        rows = 32'(rows_reg);
        if (rows == 0)
            return 1;
        return (rows > FRAME_ROWS) ? FRAME_ROWS : rows;
    endfunction

    // expected result of one macropixel, advances the counters
    function automatic conv_result_t predict_conversion(logic [31:0] word);
        conv_result_t      r;
        logic [7:0]        u;
        logic [7:0]        v;
        logic [8:0]        u_sum;
        logic [8:0]        v_sum;
        logic [SLOT_W-1:0] slot;
        r = '0;
        if (order_reg == ORDER_YUYV) begin
            r.luma_first  = word[7:0];
            u             = word[15:8];
            r.luma_second = word[23:16];
            v             = word[31:24];
        end else begin
            u             = word[7:0];
            r.luma_first  = word[15:8];
            v             = word[23:16];
            r.luma_second = word[31:24];
        end
        slot = SLOT_W'(column_pos % LINE_PAIRS);
        // even rows fill the chroma line, odd rows average against it
        if (row_pos[0] == 1'b0) begin
            line_u[slot]      = u;
            line_v[slot]      = v;
            line_filled[slot] = 1'b1;
        end else begin
            if (!line_filled[slot]) begin
                $error("stimulus reads chroma line slot %0d before any write", slot);
                error_count++;
            end
            u_sum          = {1'b0, line_u[slot]} + {1'b0, u};
            v_sum          = {1'b0, line_v[slot]} + {1'b0, v};
            r.chroma_valid = 1'b1;
            r.u_average    = u_sum[8:1];
            r.v_average    = v_sum[8:1];
        end
        r.row_end   = (column_pos + 1 >= active_pairs());
        r.frame_end = r.row_end && (row_pos + 1 >= active_rows());
        if (r.row_end) begin
            column_pos = 0;
            row_pos    = r.frame_end ? 0 : row_pos + 1;
        end else begin
            column_pos = column_pos + 1;
        end
        return r;
    endfunction

    function automatic void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            error_count++;
        end
    endfunction

    // result side: check each transfer, then maybe hold ready low
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no macropixel outstanding");
                error_count++;
            end else begin
                oldest = pending_results.pop_front();
                compare_field("luma_first", oldest.luma_first, luma_first);
                compare_field("luma_second", oldest.luma_second, luma_second);
                compare_field("chroma_valid", 8'(oldest.chroma_valid), 8'(chroma_valid));
                compare_field("u_average", oldest.u_average, u_average);
                compare_field("v_average", oldest.v_average, v_average);
                compare_field("row_end", 8'(oldest.row_end), 8'(row_end));
                compare_field("frame_end", 8'(oldest.frame_end), 8'(frame_end));
                if (oldest.chroma_valid)
                    chroma_checked++;
                if (oldest.frame_end)
                    frames_seen++;
            end
            ready_hold = $urandom_range(0, gap_max);
            if (ready_hold != 0)
                res_ready <= 1'b0;
        end else if (ready_hold != 0) begin
            ready_hold--;
            if (ready_hold == 0)
                res_ready <= 1'b1;
        end
    end

    // one macropixel transfer after a random gap
    task automatic send_macropixel(input logic [31:0] word);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid  <= 1'b1;
        macropixel <= word;
        do @(posedge clk); while (!pix_ready);
        pending_results.push_back(predict_conversion(word));
        items_sent++;
    endtask

    // register write, only called with nothing in flight
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] word);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PAIRS_PER_ROW:  pairs_reg = word[PAIRS_REG_W-1:0];
            REG_ROWS_PER_FRAME: rows_reg  = word[ROWS_REG_W-1:0];
            REG_PACKING_ORDER:  order_reg = word[0];
            default: ;
        endcase
        regs_written++;
    endtask

    // stop sending until every result has come back
    task automatic wait_for_drain();
        pix_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random bytes with the extremes mixed in
    function automatic logic [31:0] random_macropixel();
        logic [31:0] word;
        word = $urandom;
        for (int b = 0; b < 4; b++) begin
            case ($urandom_range(0, 9))
                0: word[8*b +: 8] = 8'h00;
                1: word[8*b +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return word;
    endfunction

    // one whole frame at the current size, starting at the top left
    task automatic send_frame(input int unsigned pause_pct);
        int unsigned count;
        count = active_pairs() * active_rows();
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < pause_pct)
                wait_for_drain();
            send_macropixel(random_macropixel());
        end
    endtask

    // both byte orders, byte extremes, odd frame height
    task automatic test_byte_orders();
        write_register(REG_PAIRS_PER_ROW, 2);
        write_register(REG_ROWS_PER_FRAME, 3);
        write_register(REG_PACKING_ORDER, CFG_DATA_W'(ORDER_YUYV));
        send_macropixel(32'h0000_0000);
        send_macropixel(32'hFFFF_FFFF);
        send_macropixel(32'hFFFF_FFFF);
        send_macropixel(32'h0000_0000);
        send_macropixel(32'h1234_5678);
        send_macropixel(32'h9ABC_DEF0);
        wait_for_drain();
        write_register(REG_ROWS_PER_FRAME, 2);
        write_register(REG_PACKING_ORDER, CFG_DATA_W'(ORDER_UYVY));
        send_macropixel(32'h4433_2211);
        send_macropixel(32'h8877_6655);
        send_macropixel(32'hFFFF_FFFF);
        send_macropixel(32'h00FF_00FF);
        wait_for_drain();
    endtask

    // zero width and height behave as one
    task automatic test_size_limits();
        write_register(REG_PAIRS_PER_ROW, 0);
        write_register(REG_ROWS_PER_FRAME, 0);
        write_register(REG_PACKING_ORDER, CFG_DATA_W'(ORDER_YUYV));
        send_macropixel(random_macropixel());
        send_macropixel(random_macropixel());
        wait_for_drain();
        write_register(REG_ROWS_PER_FRAME, 2);
        send_macropixel(random_macropixel());
        send_macropixel(random_macropixel());
        wait_for_drain();
    endtask

    // shrink width and height in the middle of a frame
    task automatic test_midframe_resize();
        write_register(REG_PAIRS_PER_ROW, 4);
        write_register(REG_ROWS_PER_FRAME, 4);
        repeat (6) send_macropixel(random_macropixel());
        wait_for_drain();
        // column 2 now lies past the row, so it ends the row
        write_register(REG_PAIRS_PER_ROW, 2);
        repeat (3) send_macropixel(random_macropixel());
        wait_for_drain();
        // row 3 now lies past the frame, its last pair ends the frame
        write_register(REG_ROWS_PER_FRAME, 2);
        write_register(REG_UNUSED, CFG_DATA_W'($urandom));
        repeat (2) send_macropixel(random_macropixel());
        wait_for_drain();
    endtask

    // random frame sizes and orders, mostly small
    task automatic test_random_frames();
        int unsigned            first_item;
        logic [CFG_DATA_W-1:0] word;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            gap_max = ($urandom_range(0, 4) == 0) ? 0 : IDLE_MAX;
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 19))
                    0:       word = 0;
                    1:       word = 13'h1000 | CFG_DATA_W'($urandom_range(1, 12));
                    2, 3, 4: word = CFG_DATA_W'($urandom_range(13, 64));
                    default: word = CFG_DATA_W'($urandom_range(1, 12));
                endcase
                write_register(REG_PAIRS_PER_ROW, word);
            end
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 19))
                    0:       word = 0;
                    1:       word = CFG_DATA_W'($urandom_range(7, 16));
                    default: word = CFG_DATA_W'($urandom_range(1, 6));
                endcase
                write_register(REG_ROWS_PER_FRAME, word);
            end
            if ($urandom_range(0, 4) != 0)
                write_register(REG_PACKING_ORDER, CFG_DATA_W'($urandom));
            send_frame(2);
            wait_for_drain();
        end
        gap_max = IDLE_MAX;
    endtask

    // main sequence
    initial begin
        rst_n      = 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_PAIRS_PER_ROW;
        cfg_data   <= '0;
        pix_valid  <= 1'b0;
        macropixel <= '0;
        res_ready  <= 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_byte_orders();
        test_size_limits();
        test_midframe_resize();
        test_random_frames();

        wait_for_drain();
        repeat (8) @(posedge clk);
        $display("covered %0d macropixels in %0d frames with %0d register writes,",
                 items_sent, frames_seen, regs_written);
        $display("%0d two-row chroma averages checked, %0d errors",
                 chroma_checked, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/yuv420_pkg.sv
src/packed_yuv422_to_planar_i420.sv
verif/packed_yuv422_to_planar_i420_tb.sv
